// ===== hw/rtl/masked_column_median_macros.svh =====
// assertion macros for the masked column median block
`ifndef MASKED_COLUMN_MEDIAN_MACROS_SVH
`define MASKED_COLUMN_MEDIAN_MACROS_SVH

// same-cycle implication, disabled while in reset
`define MCM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mcm assertion failed");

// implication checked a fixed number of cycles later
`define MCM_ASSERT_LATER(lbl, clk, rst_n, ante, dly, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
		else $error("mcm assertion failed");

`endif

// ===== hw/rtl/mcm_pkg.sv =====
// shared types and constants for the masked column median block
`timescale 1ns / 1ps
package mcm_pkg;

	localparam int PixW   = 16;
	localparam int NumPix = 4;
	localparam int CntW   = 3;
	localparam logic [PixW-1:0] NoValid = '1;

	typedef logic [PixW-1:0]      key_t;
	typedef key_t [NumPix-1:0]    key_vec_t;
	typedef logic [CntW-1:0]      count_t;

	typedef struct packed {
		logic     vld;
		count_t   cnt;
		key_vec_t keys;
	} sort_word_t;

endpackage

// ===== hw/rtl/mcm_sort.sv =====
// two-stage sorting network over the four pixel keys
`timescale 1ns / 1ps
module mcm_sort (
	input  logic               clk,
	input  logic               arst_n,
	input  mcm_pkg::sort_word_t in_word,
	output mcm_pkg::sort_word_t out_word
);

	mcm_pkg::key_vec_t  l1;
	mcm_pkg::key_vec_t  l2;
	mcm_pkg::key_vec_t  l3;
	logic               vld_s2;
	mcm_pkg::count_t    cnt_s2;
	mcm_pkg::key_vec_t  keys_s2;
	logic               vld_s3;
	mcm_pkg::count_t    cnt_s3;
	mcm_pkg::key_vec_t  keys_s3;

	// first two layers of the network
	always_comb begin
		l1[0] = (in_word.keys[0] < in_word.keys[1]) ? in_word.keys[0] : in_word.keys[1];
		l1[1] = (in_word.keys[0] < in_word.keys[1]) ? in_word.keys[1] : in_word.keys[0];
		l1[2] = (in_word.keys[2] < in_word.keys[3]) ? in_word.keys[2] : in_word.keys[3];
		l1[3] = (in_word.keys[2] < in_word.keys[3]) ? in_word.keys[3] : in_word.keys[2];
		l2[0] = (l1[0] < l1[2]) ? l1[0] : l1[2];
		l2[2] = (l1[0] < l1[2]) ? l1[2] : l1[0];
		l2[1] = (l1[1] < l1[3]) ? l1[1] : l1[3];
		l2[3] = (l1[1] < l1[3]) ? l1[3] : l1[1];
	end

	// last layer swaps the middle pair
	always_comb begin
		l3[0] = keys_s2[0];
		l3[3] = keys_s2[3];
		l3[1] = (keys_s2[1] < keys_s2[2]) ? keys_s2[1] : keys_s2[2];
		l3[2] = (keys_s2[1] < keys_s2[2]) ? keys_s2[2] : keys_s2[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= in_word.vld;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		cnt_s2  <= in_word.cnt;
		keys_s2 <= l2;
		cnt_s3  <= cnt_s2;
		keys_s3 <= l3;
	end

	assign out_word.vld  = vld_s3;
	assign out_word.cnt  = cnt_s3;
	assign out_word.keys = keys_s3;

endmodule

// ===== hw/rtl/mcm_select.sv =====
// picks middle key, mean of middle pair or NoValid; registers the result
`timescale 1ns / 1ps
module mcm_select (
	input  logic                clk,
	input  logic                arst_n,
	input  mcm_pkg::sort_word_t in_word,
	output logic                done,
	output logic [15:0]         median_distance
);

	logic [mcm_pkg::PixW:0]   sum;
	logic [mcm_pkg::PixW-1:0] res;
	logic                     vld_s4;
	logic [mcm_pkg::PixW-1:0] res_s4;

	always_comb begin
		sum = '0;
		res = mcm_pkg::NoValid;
		case (in_word.cnt)
			mcm_pkg::count_t'(1): res = in_word.keys[0];
			mcm_pkg::count_t'(2): begin
				sum = {1'b0, in_word.keys[0]} + {1'b0, in_word.keys[1]};
				res = sum[mcm_pkg::PixW:1];
			end
			mcm_pkg::count_t'(3): res = in_word.keys[1];
			mcm_pkg::count_t'(4): begin
				sum = {1'b0, in_word.keys[1]} + {1'b0, in_word.keys[2]};
				res = sum[mcm_pkg::PixW:1];
			end
			default: res = mcm_pkg::NoValid;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= in_word.vld;
		end
	end

	always_ff @(posedge clk) begin
		res_s4 <= res;
	end

	assign done            = vld_s4;
	assign median_distance = res_s4;

endmodule

// ===== hw/rtl/masked_column_median.sv =====
// top level of the masked column median pipeline
//
//  channel   handshake          payload
//  input     start / busy       pixel_a, pixel_b, pixel_c, pixel_d
//  result    done (strobe)      median_distance
//
// one word accepted per cycle, busy is never raised
// each result appears as a one-cycle done strobe following its start
// latency is set by the key stage, the two sort stages and the select stage
// reset clears only the stage valid bits, words in flight are dropped
// the receiver cannot stall, so nothing is held back
`timescale 1ns / 1ps
module masked_column_median (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] pixel_a,
	input  logic [15:0] pixel_b,
	input  logic [15:0] pixel_c,
	input  logic [15:0] pixel_d,
	output logic        done,
	output logic [15:0] median_distance
);

	mcm_pkg::key_vec_t   pix;
	mcm_pkg::key_vec_t   keys;
	logic [mcm_pkg::NumPix-1:0] ok;
	logic                vld_s1;
	mcm_pkg::count_t     cnt_s1;
	mcm_pkg::key_vec_t   keys_s1;
	mcm_pkg::sort_word_t word_s1;
	mcm_pkg::sort_word_t word_s3;

	assign busy = 1'b0;

	assign pix[0] = pixel_a;
	assign pix[1] = pixel_b;
	assign pix[2] = pixel_c;
	assign pix[3] = pixel_d;

	// invalid pixels become the top key so they sort past every valid one
	always_comb begin
		for (int i = 0; i < mcm_pkg::NumPix; i++) begin
			ok[i]   = ~pix[i][mcm_pkg::PixW-1];
			keys[i] = ok[i] ? pix[i] : mcm_pkg::NoValid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		cnt_s1  <= mcm_pkg::count_t'($countones(ok));
		keys_s1 <= keys;
	end

	assign word_s1.vld  = vld_s1;
	assign word_s1.cnt  = cnt_s1;
	assign word_s1.keys = keys_s1;

	mcm_sort u_sort (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_word  (word_s1),
		.out_word (word_s3)
	);

	mcm_select u_select (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_word         (word_s3),
		.done            (done),
		.median_distance (median_distance)
	);

endmodule

// ===== hw/rtl/mcm_checker.sv =====
// port-level checks for the masked column median block, bound to the top level
`timescale 1ns / 1ps
`include "masked_column_median_macros.svh"
module mcm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [15:0] pixel_a,
	input logic [15:0] pixel_b,
	input logic [15:0] pixel_c,
	input logic [15:0] pixel_d,
	input logic        done,
	input logic [15:0] median_distance
);

	logic none_valid;
	logic gave_none;
	logic range_ok;

	assign none_valid = pixel_a[15] && pixel_b[15] && pixel_c[15] && pixel_d[15];
	assign gave_none  = (median_distance == 16'hffff);
	assign range_ok   = !median_distance[15] || gave_none;

	`MCM_ASSERT_LATER(a_start_gives_done, clk, arst_n, start && !busy, 4, done)
	`MCM_ASSERT_NOW(a_done_has_start, clk, arst_n, done, $past(start && !busy, 4))
	`MCM_ASSERT_NOW(a_result_range, clk, arst_n, done, range_ok)
	`MCM_ASSERT_NOW(a_all_invalid, clk, arst_n, done && $past(none_valid, 4), gave_none)

endmodule

bind masked_column_median mcm_checker u_mcm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.pixel_a         (pixel_a),
	.pixel_b         (pixel_b),
	.pixel_c         (pixel_c),
	.pixel_d         (pixel_d),
	.done            (done),
	.median_distance (median_distance)
);
